### hdl/round_robin_thread_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// round robin thread scheduler assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and constants of the round robin thread scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int RRTS_SLOT_COUNT = 4;

    typedef enum logic [1:0] {
        ACT_SPAWN = 2'd0,
        ACT_YIELD = 2'd1,
        ACT_EXIT  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_NO_READY = 2'd2,
        STS_FINISHED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_RUNNING = 2'd1,
        SLOT_READY   = 2'd2
    } t_slot_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic act_valid;
        logic hit;
        logic last;
    } t_sts;

endpackage

### hdl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// sequencer: accepts a request, steps the slot scan, issues the result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_done,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.act_valid) begin
                    n_state = ST_EMIT;
                end else if (i_sts.hit || i_sts.last) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

### hdl/rrts_datapath.sv
// ----------------------------------------------------------------------------
// rrts_datapath
// slot table, current slot, start address memory and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = RRTS_SLOT_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_entry_address,
    input  logic [7:0]  i_exit_code,
    output logic [1:0]  o_status,
    output logic        o_switched,
    output logic [1:0]  o_from_slot,
    output logic [1:0]  o_to_slot,
    output logic [1:0]  o_spawned_slot,
    output logic        o_first_run,
    output logic [63:0] o_start_address,
    output logic [7:0]  o_final_code
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(SLOT_COUNT - 1);

    logic [1:0]            r_act;
    logic [63:0]           r_entry;
    logic [7:0]            r_code;
    logic                  r_exit_main;
    logic [SLOT_W-1:0]     r_cur;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]     n_idx;
    logic [SLOT_COUNT-1:0] r_never_ran;
    t_slot_state           r_slot_state [SLOT_COUNT];
    logic [63:0]           r_start_mem  [SLOT_COUNT];
    logic [63:0]           r_rd_data;

    t_status               r_status;
    logic                  r_switched;
    logic [SLOT_W-1:0]     r_from;
    logic [SLOT_W-1:0]     r_to;
    logic [SLOT_W-1:0]     r_spawned;
    logic                  r_first;
    logic [7:0]            r_final;

    logic                  act_valid;
    logic                  is_spawn;
    logic                  hit;
    logic                  do_spawn;
    logic                  do_switch;
    logic                  do_free;
    t_slot_state           want;
    logic [SLOT_W+1:0]     from_ext;
    logic [SLOT_W+1:0]     to_ext;
    logic [SLOT_W+1:0]     spawned_ext;

    assign act_valid = (r_act == ACT_SPAWN) || (r_act == ACT_YIELD) || (r_act == ACT_EXIT);
    assign is_spawn  = (r_act == ACT_SPAWN);
    assign want      = is_spawn ? SLOT_UNUSED : SLOT_READY;
    assign hit       = act_valid && (r_slot_state[r_idx] == want);
    assign n_idx     = (r_idx == LastIdx) ? '0 : r_idx + 1'b1;

    assign do_spawn  = i_cmd.commit && hit && is_spawn;
    assign do_switch = i_cmd.commit && hit && !is_spawn;
    assign do_free   = i_cmd.load && (i_action == ACT_EXIT) && (r_cur != '0);

    assign o_sts.act_valid = act_valid;
    assign o_sts.hit       = hit;
    assign o_sts.last      = (r_cnt == LastIdx);

    // request capture and scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_idx <= (i_action == ACT_SPAWN) ? '0 : r_cur;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_idx <= n_idx;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act       <= i_action;
            r_entry     <= i_entry_address;
            r_code      <= i_exit_code;
            r_exit_main <= (r_cur == '0);
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_state[i] <= (i == 0) ? SLOT_RUNNING : SLOT_UNUSED;
            end
            r_never_ran     <= '0;
            r_cur           <= '0;
        end else if (do_free) begin
            r_slot_state[r_cur] <= SLOT_UNUSED;
        end else if (do_spawn) begin
            r_slot_state[r_idx] <= SLOT_READY;
            r_never_ran[r_idx]  <= 1'b1;
        end else if (do_switch) begin
            if ((r_cur != r_idx) && (r_slot_state[r_cur] != SLOT_UNUSED)) begin
                r_slot_state[r_cur] <= SLOT_READY;
            end
            r_slot_state[r_idx] <= SLOT_RUNNING;
            r_never_ran[r_idx]  <= 1'b0;
            r_cur               <= r_idx;
        end
    end

    // start address memory
    always_ff @(posedge i_clk) begin
        if (do_spawn) begin
            r_start_mem[r_idx] <= r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_switch) begin
            r_rd_data <= r_start_mem[r_idx];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= STS_OK;
            r_switched <= 1'b0;
            r_from     <= '0;
            r_to       <= '0;
            r_spawned  <= '0;
            r_first    <= 1'b0;
            r_final    <= '0;
        end else if (i_cmd.commit) begin
            if (hit) begin
                if (is_spawn) begin
                    r_spawned <= r_idx;
                end else begin
                    r_switched <= 1'b1;
                    r_from     <= r_cur;
                    r_to       <= r_idx;
                    r_first    <= r_never_ran[r_idx];
                end
            end else begin
                case (r_act)
                    ACT_SPAWN: begin
                        r_status <= STS_FULL;
                    end
                    ACT_YIELD: begin
                        r_status <= STS_NO_READY;
                    end
                    ACT_EXIT: begin
                        if (r_exit_main) begin
                            r_status <= STS_FINISHED;
                            r_final  <= r_code;
                        end else begin
                            r_status <= STS_NO_READY;
                        end
                    end
                    default: begin
                        r_status <= STS_OK;
                    end
                endcase
            end
        end
    end

    assign from_ext    = {2'b00, r_from};
    assign to_ext      = {2'b00, r_to};
    assign spawned_ext = {2'b00, r_spawned};

    assign o_status        = r_status;
    assign o_switched      = r_switched;
    assign o_from_slot     = from_ext[1:0];
    assign o_to_slot       = to_ext[1:0];
    assign o_spawned_slot  = spawned_ext[1:0];
    assign o_first_run     = r_first;
    assign o_start_address = r_first ? r_rd_data : '0;
    assign o_final_code    = r_final;

endmodule

### hdl/round_robin_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// cooperative round robin scheduler: spawn, yield and exit bookkeeping
// ----------------------------------------------------------------------------
// usage
//   a request (i_action, i_entry_address, i_exit_code) is taken at a clock
//   edge with start high and busy low; busy then stays high until the result
//   has been shown
//   each request gives one result on the o_ ports, valid for the single
//   cycle in which o_done is high; the receiver cannot stall it
//   the slot scan looks at one slot per cycle; a valid request examines
//   1 to SLOT_COUNT slots before o_done is raised, and the next request
//   can be taken in the cycle after o_done
//   an unknown action examines no slot and returns an all-zero result
//   reset (synchronous, active low) makes slot 0 running, all other slots
//   unused, and returns the sequencer to idle; no clearing pass is needed
//   start addresses are stored in a one-port memory read after a switch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_thread_scheduler_top
    import rrts_pkg::*;
#(
    parameter int SLOT_COUNT = RRTS_SLOT_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_entry_address,
    input  logic [7:0]  i_exit_code,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_switched,
    output logic [1:0]  o_from_slot,
    output logic [1:0]  o_to_slot,
    output logic [1:0]  o_spawned_slot,
    output logic        o_first_run,
    output logic [63:0] o_start_address,
    output logic [7:0]  o_final_code
);

    t_cmd cmd;
    t_sts sts;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rrts_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_entry_address (i_entry_address),
        .i_exit_code     (i_exit_code),
        .o_status        (o_status),
        .o_switched      (o_switched),
        .o_from_slot     (o_from_slot),
        .o_to_slot       (o_to_slot),
        .o_spawned_slot  (o_spawned_slot),
        .o_first_run     (o_first_run),
        .o_start_address (o_start_address),
        .o_final_code    (o_final_code)
    );

endmodule

### hdl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_top_defines.svh"

module rrts_checker
    import rrts_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic       o_switched,
    input logic       o_first_run,
    input logic [7:0] o_final_code
);

    // accepted request holds off the next one
    `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after request")
    // result strobe lasts one cycle
    `RRTS_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe longer than one cycle")
    // switch only on ok status
    `RRTS_ASSERT_NOW(a_switch_ok, o_done && (o_status != STS_OK), !o_switched,
        "switch reported with error status")
    // first run only with a switch
    `RRTS_ASSERT_NOW(a_first_switch, o_done && !o_switched, !o_first_run,
        "first run without switch")
    // exit code passed on only when all finished
    `RRTS_ASSERT_NOW(a_final_code, o_done && (o_status != STS_FINISHED), o_final_code == 8'd0,
        "final code set without finish")

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (.*);
